[sv/spq_pkg.sv]
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int PERIOD_W      = 16;

  // request kinds
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_POP_LO = 3'd2;
  localparam logic [2:0] KIND_POP_HI = 3'd3;
  localparam logic [2:0] KIND_QUERY  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [2:0]          kind;
    logic [PERIOD_W-1:0] period;
  } spq_req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [PERIOD_W-1:0] removed_period;
    logic                present;
    logic [4:0]          entry_count;
  } spq_rsp_t;

endpackage

[sv/spq_ram.sv]
module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/spq_ctrl.sv]
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  spq_req_t            req,
  output logic                ready,
  output logic                done,
  input  logic                take,
  output spq_rsp_t            rsp,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [PERIOD_W-1:0] ram_wdata,
  output logic [AW-1:0]       ram_raddr,
  input  logic [PERIOD_W-1:0] ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT_UP, S_WRITE_KEY, S_SHIFT_DN, S_POP_LO, S_POP_HI, S_FINISH
  } state_t;

  localparam logic [CW-1:0] CNT_ZERO = '0;
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  state_t              state, state_next;
  logic [2:0]          kind, kind_next;
  logic [PERIOD_W-1:0] key, key_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       pos, pos_next;
  logic [2:0]          status, status_next;
  logic [PERIOD_W-1:0] removed, removed_next;
  logic                present, present_next;

  logic [CW-1:0] idx_inc, idx_inc2, idx_dec, count_inc, count_dec;
  logic          ge, eq, last;
  logic [CW+4:0] count_wide;

  assign idx_inc   = idx + CNT_ONE;
  assign idx_inc2  = idx + CW'(2);
  assign idx_dec   = idx - CNT_ONE;
  assign count_inc = count + CNT_ONE;
  assign count_dec = count - CNT_ONE;
  assign ge        = (ram_rdata >= key);
  assign eq        = (ram_rdata == key);
  assign last      = (idx_inc == count);

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    key_next     = key;
    count_next   = count;
    idx_next     = idx;
    pos_next     = pos;
    status_next  = status;
    removed_next = removed;
    present_next = present;
    ram_we       = 1'b0;
    ram_waddr    = idx[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_inc[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (start) begin
          kind_next    = req.kind;
          key_next     = req.period;
          status_next  = ST_OK;
          removed_next = '0;
          present_next = 1'b0;
          idx_next     = CNT_ZERO;
          ram_raddr    = '0;
          if (req.kind == KIND_INSERT || req.kind == KIND_DELETE ||
              req.kind == KIND_QUERY) begin
            if (count == CNT_ZERO) begin
              // empty store: resolve at once
              if (req.kind == KIND_INSERT) begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = req.period;
                count_next = CNT_ONE;
              end else if (req.kind == KIND_DELETE) begin
                status_next = ST_NOT_FOUND;
              end
              state_next = S_FINISH;
            end else begin
              state_next = S_SCAN;
            end
          end else if (req.kind == KIND_POP_LO || req.kind == KIND_POP_HI) begin
            if (count == CNT_ZERO) begin
              status_next = ST_EMPTY;
              state_next  = S_FINISH;
            end else if (req.kind == KIND_POP_LO) begin
              state_next = S_POP_LO;
            end else begin
              ram_raddr  = count_dec[AW-1:0];
              state_next = S_POP_HI;
            end
          end else begin
            state_next = S_FINISH;
          end
        end
      end

      S_SCAN: begin
        // ram_rdata holds entry idx; stop at the first entry not below key, or at the last entry
        if (ge || last) begin
          state_next = S_FINISH;
          if (kind == KIND_INSERT) begin
            if (eq) begin
              status_next  = ST_DUP;
              present_next = 1'b1;
            end else if (count == CNT_FULL) begin
              status_next = ST_FULL;
            end else if (!ge) begin
              // append after the largest entry
              ram_we     = 1'b1;
              ram_waddr  = count[AW-1:0];
              ram_wdata  = key;
              count_next = count_inc;
            end else begin
              pos_next   = idx;
              idx_next   = count_dec;
              ram_raddr  = count_dec[AW-1:0];
              state_next = S_SHIFT_UP;
            end
          end else if (kind == KIND_DELETE) begin
            if (!eq) begin
              status_next = ST_NOT_FOUND;
            end else begin
              removed_next = key;
              if (last) begin
                count_next = count_dec;
              end else begin
                state_next = S_SHIFT_DN;
              end
            end
          end else begin
            present_next = eq;
          end
        end else begin
          idx_next = idx_inc;
        end
      end

      S_SHIFT_UP: begin
        // move entry idx up one slot, walking down to the insert point
        ram_we    = 1'b1;
        ram_waddr = idx_inc[AW-1:0];
        if (idx == pos) begin
          state_next = S_WRITE_KEY;
        end else begin
          idx_next  = idx_dec;
          ram_raddr = idx_dec[AW-1:0];
        end
      end

      S_WRITE_KEY: begin
        ram_we     = 1'b1;
        ram_waddr  = pos[AW-1:0];
        ram_wdata  = key;
        count_next = count_inc;
        state_next = S_FINISH;
      end

      S_SHIFT_DN: begin
        // ram_rdata holds entry idx+1; pull it down into slot idx
        ram_we = 1'b1;
        if (idx_inc2 == count) begin
          count_next = count_dec;
          state_next = S_FINISH;
        end else begin
          idx_next  = idx_inc;
          ram_raddr = idx_inc2[AW-1:0];
        end
      end

      S_POP_LO: begin
        removed_next = ram_rdata;
        if (count == CNT_ONE) begin
          count_next = CNT_ZERO;
          state_next = S_FINISH;
        end else begin
          state_next = S_SHIFT_DN;
        end
      end

      S_POP_HI: begin
        removed_next = ram_rdata;
        count_next   = count_dec;
        state_next   = S_FINISH;
      end

      S_FINISH: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CNT_ZERO;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    kind    <= kind_next;
    key     <= key_next;
    idx     <= idx_next;
    pos     <= pos_next;
    status  <= status_next;
    removed <= removed_next;
    present <= present_next;
  end

  assign count_wide = {5'd0, count};

  assign ready = (state == S_IDLE);
  assign done  = (state == S_FINISH);

  always_comb begin
    rsp.status         = status;
    rsp.removed_period = removed;
    rsp.present        = present;
    rsp.entry_count    = count_wide[4:0];
  end

endmodule

[sv/sorted_period_queue_unit.sv]
// Sorted period queue: keeps up to DEPTH distinct 16-bit periods in ascending order in
// a single-port-write, registered-read RAM and serves one request at a time (insert,
// delete value, pop smallest, pop largest, query), returning one response per request.
// A request scans the stored entries from the smallest, one RAM read per cycle, until
// it reaches the first entry not below the key; an insert or delete then moves the
// entries behind that point one slot per cycle through the same RAM port. Pops skip
// the scan. An empty store or an unused kind is resolved at once, without a scan. The
// response sits in an output register, so the next request is taken while it waits.
module sorted_period_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  spq_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output spq_rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);

  logic                ctrl_ready, ctrl_done, ctrl_take, start;
  spq_rsp_t            ctrl_rsp;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [PERIOD_W-1:0] ram_wdata, ram_rdata;

  assign req_stall = !ctrl_ready;
  assign start     = req_valid && ctrl_ready;
  // hand the result over once the output register is free or draining
  assign ctrl_take = ctrl_done && (!rsp_valid || !rsp_stall);

  spq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .ready    (ctrl_ready),
    .done     (ctrl_done),
    .take     (ctrl_take),
    .rsp      (ctrl_rsp),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  spq_ram #(
    .WIDTH(PERIOD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (ctrl_take) begin
      rsp <= ctrl_rsp;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !ctrl_ready)
    else $error("sequencer still idle after accepting a request");

  a_rsp_from_take: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(ctrl_take))
    else $error("response appeared without a finished request");

  a_present_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.present |-> (rsp.status == ST_OK || rsp.status == ST_DUP))
    else $error("present flag set with an error status");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int SPQ_DEPTH = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int POOL_N = 20;
  localparam int HOLD_START = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 50;

  // request kinds the block ignores
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  class period_queue_scoreboard;
    logic [15:0] periods[SPQ_DEPTH];
    int unsigned n_stored;
    spq_rsp_t expected_rsps[$];
    int unsigned errors;

    function new();
      n_stored = 0;
      errors = 0;
    endfunction

    // Update the sorted copy and queue the response this request must produce.
    function void note_request(spq_req_t r);
      spq_rsp_t e;
      int unsigned pos;
      bit hit;
      e = '0;
      e.status = ST_OK;
      pos = 0;
      while (pos < n_stored && periods[pos] < r.period) pos++;
      hit = (pos < n_stored) && (periods[pos] == r.period);
      case (r.kind)
        KIND_INSERT: begin
          if (hit) begin
            e.status = ST_DUP;
            e.present = 1'b1;
          end else if (n_stored >= SPQ_DEPTH) begin
            e.status = ST_FULL;
          end else begin
            for (int i = n_stored; i > pos; i--) periods[i] = periods[i-1];
            periods[pos] = r.period;
            n_stored++;
          end
        end
        KIND_DELETE: begin
          if (hit) begin
            e.removed_period = r.period;
            remove_at(pos);
          end else begin
            e.status = ST_NOT_FOUND;
          end
        end
        KIND_POP_LO: begin
          if (n_stored == 0) begin
            e.status = ST_EMPTY;
          end else begin
            e.removed_period = periods[0];
            remove_at(0);
          end
        end
        KIND_POP_HI: begin
          if (n_stored == 0) begin
            e.status = ST_EMPTY;
          end else begin
            e.removed_period = periods[n_stored-1];
            n_stored--;
          end
        end
        KIND_QUERY: e.present = hit;
        default: ;
      endcase
      e.entry_count = 5'(n_stored);
      expected_rsps.push_back(e);
    endfunction

    function void remove_at(int unsigned pos);
      for (int unsigned i = pos; i + 1 < n_stored; i++) periods[i] = periods[i+1];
      n_stored--;
    endfunction

    function void check_response(spq_rsp_t got);
      spq_rsp_t e;
      if (expected_rsps.size() == 0) begin
        $error("response with none pending: status %0d removed_period %0h", got.status,
               got.removed_period);
        errors++;
        return;
      end
      e = expected_rsps.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
      if (got.removed_period !== e.removed_period) begin
        $error("removed_period: expected %0h, actual %0h", e.removed_period,
               got.removed_period);
        errors++;
      end
      if (got.present !== e.present) begin
        $error("present: expected %0d, actual %0d", e.present, got.present);
        errors++;
      end
      if (got.entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", e.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  spq_req_t req;
  logic rsp_valid;
  logic rsp_stall;
  spq_rsp_t rsp;

  period_queue_scoreboard sb;
  logic [15:0] key_pool[POOL_N];
  int unsigned accepted_items = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;

  sorted_period_queue_unit #(.DEPTH(SPQ_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sorted_period_queue_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // Receiver: stall in modes of random density, plus one long hold-off so the
  // block backs up and stalls its input.
  initial begin
    bit long_hold_done;
    int unsigned mode_left;
    int unsigned stall_pct;
    long_hold_done = 0;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      if (!long_hold_done && accepted_items >= HOLD_START) begin
        long_hold_done = 1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(200, 20);
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        mode_left--;
        rsp_stall <= ($urandom_range(99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  // Send one transaction; the sender works in bursts with idle gaps between them.
  task automatic send_req(input spq_req_t item);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
      burst_left = $urandom_range(60, 1);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(item);
    accepted_items++;
    burst_left--;
  endtask

  function automatic logic [15:0] pick_key();
    if ($urandom_range(9) < 6) return key_pool[$urandom_range(POOL_N - 1)];
    return 16'($urandom());
  endfunction

  // Prefer periods that are stored so deletes and queries mostly hit.
  function automatic logic [15:0] pick_target();
    if (sb.n_stored > 0 && $urandom_range(9) < 6) return sb.periods[$urandom_range(sb.n_stored - 1)];
    return pick_key();
  endfunction

  task automatic run_directed();
    spq_req_t plan[$];
    plan.push_back('{kind: KIND_QUERY, period: 16'h0000});
    plan.push_back('{kind: KIND_POP_LO, period: 16'hFFFF});
    plan.push_back('{kind: KIND_POP_HI, period: 16'h0000});
    plan.push_back('{kind: KIND_DELETE, period: 16'h1234});
    plan.push_back('{kind: KIND_INSERT, period: 16'hFFFF});
    plan.push_back('{kind: KIND_INSERT, period: 16'h0000});
    plan.push_back('{kind: KIND_INSERT, period: 16'h8000});
    plan.push_back('{kind: KIND_INSERT, period: 16'h7FFF});
    plan.push_back('{kind: KIND_INSERT, period: 16'h0000});
    plan.push_back('{kind: KIND_QUERY, period: 16'h7FFF});
    plan.push_back('{kind: KIND_QUERY, period: 16'h7FFE});
    plan.push_back('{kind: KIND_DELETE, period: 16'h8000});
    plan.push_back('{kind: KIND_DELETE, period: 16'h8001});
    plan.push_back('{kind: KIND_SPARE_LO, period: 16'hFFFF});
    plan.push_back('{kind: 3'(KIND_SPARE_LO + 3'd1), period: 16'hAAAA});
    plan.push_back('{kind: KIND_SPARE_HI, period: 16'h5555});
    plan.push_back('{kind: KIND_INSERT, period: 16'hAAAA});
    plan.push_back('{kind: KIND_POP_LO, period: 16'h0000});
    plan.push_back('{kind: KIND_POP_HI, period: 16'hFFFF});
    plan.push_back('{kind: KIND_POP_LO, period: 16'h5555});
    plan.push_back('{kind: KIND_POP_LO, period: 16'h0000});
    plan.push_back('{kind: KIND_POP_HI, period: 16'h0000});
    plan.push_back('{kind: KIND_DELETE, period: 16'hFFFF});
    foreach (plan[i]) send_req(plan[i]);
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned phase_left;
    int unsigned roll;
    int unsigned t_ins, t_del, t_plo, t_phi, t_qry;
    phase_e phase;
    spq_req_t item;
    sent = 0;
    phase = PH_FILL;
    phase_left = 60;
    while (sent < n_items) begin
      if (phase_left == 0) begin
        phase = phase_e'($urandom_range(2));
        phase_left = $urandom_range(150, 30);
      end
      phase_left--;
      case (phase)
        PH_FILL: begin
          t_ins = 70; t_del = 80; t_plo = 85; t_phi = 90; t_qry = 98;
        end
        PH_DRAIN: begin
          t_ins = 15; t_del = 40; t_plo = 62; t_phi = 84; t_qry = 97;
        end
        default: begin
          t_ins = 35; t_del = 55; t_plo = 65; t_phi = 75; t_qry = 97;
        end
      endcase
      roll = $urandom_range(99);
      item.period = 16'($urandom());
      if (roll < t_ins) begin
        item.kind = KIND_INSERT;
        item.period = pick_key();
      end else if (roll < t_del) begin
        item.kind = KIND_DELETE;
        item.period = pick_target();
      end else if (roll < t_plo) begin
        item.kind = KIND_POP_LO;
      end else if (roll < t_phi) begin
        item.kind = KIND_POP_HI;
      end else if (roll < t_qry) begin
        item.kind = KIND_QUERY;
        item.period = pick_target();
      end else begin
        item.kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
      end
      send_req(item);
      // ignored kinds do not count toward the item total
      if (item.kind < KIND_SPARE_LO) sent++;
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = 16'($urandom());
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(RANDOM_ITEMS);
    req_valid <= 1'b0;
    while (sb.expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS sorted_period_queue_unit");
    end else begin
      $display("FAIL sorted_period_queue_unit");
    end
    $finish;
  end

endmodule
